>>> sv/md5s_pkg.sv
// Package for the MD5 stream hasher: constants, round tables and types.
// Used by the core, front and back modules; depends on nothing.
`default_nettype none
package md5s_pkg;
	localparam int unsigned BUF_WORDS = 16;
	localparam int unsigned FIFO_DEPTH = 4;
	localparam logic [31:0] MD5_A0 = 32'h67452301;
	localparam logic [31:0] MD5_B0 = 32'hefcdab89;
	localparam logic [31:0] MD5_C0 = 32'h98badcfe;
	localparam logic [31:0] MD5_D0 = 32'h10325476;
	localparam logic [7:0] PAD_MARK = 8'h80;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       end_of_message;
	} in_word_t;

	typedef struct packed {
		logic [63:0] digest_half;
		logic        final_half;
	} out_word_t;

	function automatic logic [31:0] round_const(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
			6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
			6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
			6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
			6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
			6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
			6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
			6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
			6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
			6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
			6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
			6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
			default: k = 32'heb86d391;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] rot_amount(input logic [5:0] i);
		logic [4:0] s;
		case ({i[5:4], i[1:0]})
			4'd0: s = 5'd7;  4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
			4'd4: s = 5'd5;  4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
			4'd8: s = 5'd4;  4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6; 4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
		endcase
		return s;
	endfunction

	function automatic logic [3:0] msg_index(input logic [5:0] i);
		logic [3:0] g;
		case (i[5:4])
			2'd0: g = i[3:0];
			2'd1: g = 4'(5 * i[3:0] + 1);
			2'd2: g = 4'(3 * i[3:0] + 5);
			default: g = 4'(7 * i[3:0]);
		endcase
		return g;
	endfunction
endpackage
`default_nettype wire

>>> sv/md5s_stream_if.sv
// Valid/ready stream interface carrying one word of a given type.
// Depends on nothing.
`default_nettype none
interface md5s_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> sv/md5_stream_hasher_core.sv
// Top level of the MD5 stream hasher: front queue and back engine.
// Depends on md5s_pkg, md5s_stream_if, md5s_front and md5s_back.
// Throughput: one byte per cycle inside a block while the queue is not full;
// each full block then holds the input during its round and add states.
// Final word: it passes the queue, then padding to the block end and the
// rounds, all twice if a second block is needed, then the two digest words.
// A final word that fills a block first waits out that block's rounds and add.
// Reset clears the queue and restores the initial chaining words at once.
`default_nettype none
module md5_stream_hasher_core #(
	parameter int unsigned FIFO_DEPTH = md5s_pkg::FIFO_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	md5s_stream_if.sink   in_ch,
	md5s_stream_if.source out_ch
);
	logic               q_valid, q_pop;
	md5s_pkg::in_word_t q_word;

	md5s_front #(.DEPTH(FIFO_DEPTH)) u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.q_valid(q_valid), .q_word(q_word), .q_pop(q_pop)
	);

	md5s_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_word(q_word),
		.q_pop(q_pop), .out_ch(out_ch)
	);
endmodule
`default_nettype wire

>>> sv/md5s_ram.sv
// Generic simple dual-port RAM with one write and one registered read port.
// Depends on nothing.
`default_nettype none
module md5s_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> sv/md5s_front.sv
// Front part: accepts input words and queues the ones that carry work.
// Depends on md5s_pkg and md5s_stream_if.
`default_nettype none
module md5s_front #(
	parameter int unsigned DEPTH = md5s_pkg::FIFO_DEPTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	md5s_stream_if.sink                in_ch,
	output      logic                  q_valid,
	output      md5s_pkg::in_word_t    q_word,
	input  wire logic                  q_pop
);
	localparam int unsigned AW = $clog2(DEPTH);
	md5s_pkg::in_word_t fifo_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic push, pop, useful;

	assign useful = in_ch.payload.byte_valid | in_ch.payload.end_of_message;
	assign in_ch.ready = (cnt_q != AW'(0) + (AW+1)'(DEPTH));
	assign push = in_ch.valid & in_ch.ready & useful;
	assign pop = q_pop & q_valid;
	assign q_valid = (cnt_q != '0);
	assign q_word = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= in_ch.payload;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= AW'(wr_q + 1'b1);
			if (pop) rd_q <= AW'(rd_q + 1'b1);
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(DEPTH)) else $error("queue overflow");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> !q_valid) else $error("pop from empty queue");
	a_idle_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && !useful && !pop) |=> $stable(cnt_q))
		else $error("idle word queued");
endmodule
`default_nettype wire

>>> sv/md5s_back.sv
// Back part: packs bytes, pads, runs the 64 rounds and emits the digest.
// Depends on md5s_pkg, md5s_stream_if and md5s_ram.
`default_nettype none
module md5s_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_valid,
	input  wire md5s_pkg::in_word_t q_word,
	output      logic               q_pop,
	md5s_stream_if.source           out_ch
);
	localparam logic [2:0] ST_IN = 3'd0;
	localparam logic [2:0] ST_PAD = 3'd1;
	localparam logic [2:0] ST_RND = 3'd2;
	localparam logic [2:0] ST_ADD = 3'd3;
	localparam logic [2:0] ST_OUT0 = 3'd4;
	localparam logic [2:0] ST_OUT1 = 3'd5;

	logic [2:0]  state_q;
	logic [31:0] h_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [63:0] len_q;
	logic [5:0]  fill_q;
	logic [31:0] wbuf_q;
	logic        fin_q, last_blk_q, pend_q;
	logic [6:0]  rnd_q;

	logic        we;
	logic [3:0]  waddr, raddr;
	logic [31:0] wdata, rdata, wnext;
	logic [5:0]  ri;
	logic [31:0] f, sum, rot;
	logic [7:0]  pbyte;

	md5s_ram #(.WIDTH(32), .DEPTH(md5s_pkg::BUF_WORDS)) u_buf (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// Round i reads its message word in the cycle before; rnd_q starts at 7f, then counts 0..64.
	assign ri = rnd_q[5:0];
	assign raddr = md5s_pkg::msg_index(6'(rnd_q + 7'd1));

	always_comb begin
		case (ri[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (d_q & b_q) | (~d_q & c_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
		sum = a_q + f + md5s_pkg::round_const(ri) + rdata;
		rot = (sum << md5s_pkg::rot_amount(ri)) | (sum >> (6'd32 - 6'(md5s_pkg::rot_amount(ri))));
	end

	always_comb begin
		if (state_q == ST_PAD)
			pbyte = (fin_q) ? 8'h00 : md5s_pkg::PAD_MARK;
		else
			pbyte = q_word.data_byte;
		wnext = wbuf_q;
		case (fill_q[1:0])
			2'd0: wnext = {24'h0, pbyte};
			2'd1: wnext[15:8] = pbyte;
			2'd2: wnext[23:16] = pbyte;
			default: wnext[31:24] = pbyte;
		endcase
		we = 1'b0;
		waddr = fill_q[5:2];
		wdata = wnext;
		if (state_q == ST_IN && q_valid && q_word.byte_valid && fill_q[1:0] == 2'd3)
			we = 1'b1;
		if (state_q == ST_PAD) begin
			we = (fill_q[1:0] == 2'd3);
			if (last_blk_q && fill_q[5:2] == 4'd14) wdata = len_q[31:0];
			if (last_blk_q && fill_q[5:2] == 4'd15) wdata = len_q[63:32];
		end
	end

	assign q_pop = (state_q == ST_IN) && q_valid;
	assign out_ch.valid = (state_q == ST_OUT0) || (state_q == ST_OUT1);
	assign out_ch.payload.final_half = (state_q == ST_OUT1);
	always_comb begin
		logic [31:0] x, y;
		x = (state_q == ST_OUT1) ? h_q[2] : h_q[0];
		y = (state_q == ST_OUT1) ? h_q[3] : h_q[1];
		out_ch.payload.digest_half = {x[7:0], x[15:8], x[23:16], x[31:24],
			y[7:0], y[15:8], y[23:16], y[31:24]};
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IN && q_valid && q_word.byte_valid) wbuf_q <= wnext;
		if (state_q == ST_PAD) wbuf_q <= wnext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IN;
			h_q[0] <= md5s_pkg::MD5_A0; h_q[1] <= md5s_pkg::MD5_B0;
			h_q[2] <= md5s_pkg::MD5_C0; h_q[3] <= md5s_pkg::MD5_D0;
			a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0;
			len_q <= '0; fill_q <= '0; fin_q <= 1'b0; last_blk_q <= 1'b0;
			pend_q <= 1'b0;
			rnd_q <= '0;
		end else begin
			case (state_q)
				ST_IN: begin
					if (q_valid) begin
						if (q_word.byte_valid) begin
							len_q <= len_q + 64'd8;
							fill_q <= 6'(fill_q + 1'b1);
							if (fill_q == 6'd63) begin
								// An end flag on the word that fills the block waits for the rounds.
								state_q <= ST_RND;
								rnd_q <= 7'h7f;
								last_blk_q <= 1'b0;
								pend_q <= q_word.end_of_message;
								a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
							end
						end
						if (q_word.byte_valid && fill_q == 6'd63) begin
						end else if (q_word.end_of_message) begin
							state_q <= ST_PAD;
							fin_q <= 1'b0;
							last_blk_q <= (6'(fill_q + 6'(q_word.byte_valid)) < 6'd56);
						end
					end
				end
				ST_PAD: begin
					fin_q <= 1'b1;
					fill_q <= 6'(fill_q + 1'b1);
					if (fill_q == 6'd63) begin
						state_q <= ST_RND;
						rnd_q <= 7'h7f;
						a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
					end
				end
				ST_RND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q != 7'h7f) begin
						a_q <= d_q; d_q <= c_q; c_q <= b_q; b_q <= b_q + rot;
						if (rnd_q == 7'd63) state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
					if (!fin_q) begin
						if (pend_q) begin
							state_q <= ST_PAD;
							last_blk_q <= 1'b1;
							pend_q <= 1'b0;
						end else begin
							state_q <= ST_IN;
						end
					end else if (last_blk_q) state_q <= ST_OUT0;
					else begin
						state_q <= ST_PAD;
						last_blk_q <= 1'b1;
					end
				end
				ST_OUT0: if (out_ch.ready) state_q <= ST_OUT1;
				ST_OUT1: begin
					if (out_ch.ready) begin
						state_q <= ST_IN;
						h_q[0] <= md5s_pkg::MD5_A0; h_q[1] <= md5s_pkg::MD5_B0;
						h_q[2] <= md5s_pkg::MD5_C0; h_q[3] <= md5s_pkg::MD5_D0;
						len_q <= '0; fill_q <= '0; fin_q <= 1'b0;
					end
				end
				default: state_q <= ST_IN;
			endcase
		end
	end

	a_fill_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RND) |-> (fill_q == 6'd0)) else $error("fill during rounds");
	a_out_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT0 && out_ch.ready) |=> (state_q == ST_OUT1))
		else $error("digest halves out of order");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == ST_IN)) else $error("pop while busy");
endmodule
`default_nettype wire
